@@ design/esc_pkg.sv @@
// Package for the epoch-seconds to calendar converter.
// Holds reciprocal constants, month tables and year helpers.
// No dependencies.
`default_nettype none

package esc_pkg;

  // days = (secs >> 7) / 675, exact for a 25-bit operand
  localparam int unsigned DaySecShift = 7;
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  localparam int unsigned DayRecipShift = 35;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // years since 1970 estimate = days / 365, exact for a 16-bit operand
  localparam logic [16:0] YEAR_RECIP = 17'd91930;
  localparam int unsigned YearRecipShift = 25;

  // weekday quotient = (days + 4) / 7
  localparam logic [16:0] WDAY_RECIP = 17'd74899;
  localparam int unsigned WdayRecipShift = 19;
  localparam logic [15:0] WDAY_OFFSET = 16'd4;

  // hour = (tod >> 4) / 225
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam int unsigned HourRecipShift = 21;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // minute = (rest >> 2) / 15
  localparam logic [10:0] MIN_RECIP = 11'd1093;
  localparam int unsigned MinRecipShift = 14;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;

  localparam logic [11:0] BASE_YEAR = 12'd1970;
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  // year offset of 2100, the only non-leap multiple of four in range
  localparam logic [7:0] CENTURY_OFS = 8'd130;

  typedef logic [7:0] year_ofs_t;
  typedef logic [8:0] yday_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [8:0]  yday;
  } date_t;

  function automatic logic is_leap(input year_ofs_t yo);
    is_leap = (yo[1:0] == 2'd2) && (yo != CENTURY_OFS);
  endfunction

  // days from 1970-01-01 to Jan 1 of year 1970 + yo, valid up to 2106
  function automatic logic [15:0] year_start(input year_ofs_t yo);
    logic [8:0] yo_p1;
    logic [5:0] leaps;
    yo_p1 = {1'b0, yo} + 9'd1;
    leaps = 6'(yo_p1 >> 2) - ((yo > CENTURY_OFS) ? 6'd1 : 6'd0);
    year_start = 16'(17'(yo) * 17'(DAYS_PER_YEAR)) + 16'(leaps);
  endfunction

  // days in the year before the first day of month m
  function automatic yday_t month_start(input logic [3:0] m, input logic leap);
    yday_t base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    month_start = base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

`default_nettype wire

@@ design/epoch_seconds_to_calendar.sv @@
// Top level of the epoch-seconds to calendar converter.
// Seven-stage pipeline built from reciprocal multiplies; uses esc_pkg.
//
// Usage:
//   Input channel: drive in_epoch_seconds and raise start; the item is taken
//   at each rising edge where start is high and busy is low. busy is always
//   low, so a new item may be given in every cycle.
//   Result channel: out_valid is high for one cycle with the calendar fields
//   of one item on the out_ ports; results leave in input order.
//   Throughput: one item per cycle, set by the pipeline, in which every
//   constant division is a multiply by a reciprocal, with the multiplies
//   spread over stages 1, 2, 4 and 6.
//   Reset: rst_n low clears every stage valid bit; items in flight are
//   dropped and no result appears until new items are taken.
//   The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module epoch_seconds_to_calendar import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  output logic [11:0]      out_year_full,
  output logic [3:0]       out_month_index,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour_of_day,
  output logic [5:0]       out_minute_of_hour,
  output logic [5:0]       out_second_of_minute,
  output logic [2:0]       out_weekday,
  output logic [8:0]       out_day_of_year
);

  logic [6:0] v_r;

  // stage 1
  logic [50:0] s1_prod;
  logic [15:0] s1_days_nxt, s1_days_r;
  logic [31:0] s1_secs_r;

  // stage 2
  logic [31:0] s2_dsec_nxt, s2_dsec_r;
  logic [32:0] s2_yprod, s2_wprod;
  logic [15:0] s2_wd_nxt, s2_wd_r;
  year_ofs_t   s2_yo_r;
  logic [12:0] s2_wq_r;
  logic [15:0] s2_days_r;
  logic [31:0] s2_secs_r;

  // stage 3
  logic [16:0] s3_tod_nxt, s3_tod_r;
  logic [16:0] s3_rem0_nxt, s3_rem0_r;
  logic [2:0]  s3_wday_nxt, s3_wday_r;
  year_ofs_t   s3_yo_r;

  // stage 4
  logic [26:0] s4_hprod;
  logic [4:0]  s4_hour_nxt, s4_hour_r;
  year_ofs_t   s4_yo_nxt, s4_yo_r;
  yday_t       s4_rem_nxt, s4_rem_r;
  logic        s4_leap_r;
  logic [16:0] s4_tod_r;
  logic [2:0]  s4_wday_r;

  // stage 5
  logic [11:0] s5_rest_nxt, s5_rest_r;
  date_t       s5_date_nxt, s5_date_r;

  // stage 6
  logic [20:0] s6_mprod;
  logic [5:0]  s6_min_nxt, s6_min_r;
  logic [11:0] s6_rest_r;
  date_t       s6_date_r;

  // stage 7
  logic [5:0]  s7_sec_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], start && !busy};
    end
  end

  // stage 1: whole days
  assign s1_prod     = 51'(in_epoch_seconds[31:DaySecShift]) * 51'(DAY_RECIP);
  assign s1_days_nxt = s1_prod[DayRecipShift +: 16];

  always_ff @(posedge clk) begin
    s1_days_r <= s1_days_nxt;
    s1_secs_r <= in_epoch_seconds;
  end

  // stage 2: day seconds, year estimate, weekday quotient
  assign s2_dsec_nxt = 32'(s1_days_r) * 32'(SECS_PER_DAY);
  assign s2_yprod    = 33'(s1_days_r) * 33'(YEAR_RECIP);
  assign s2_wd_nxt   = s1_days_r + WDAY_OFFSET;
  assign s2_wprod    = 33'(s2_wd_nxt) * 33'(WDAY_RECIP);

  always_ff @(posedge clk) begin
    s2_dsec_r <= s2_dsec_nxt;
    s2_yo_r   <= s2_yprod[YearRecipShift +: 8];
    s2_wd_r   <= s2_wd_nxt;
    s2_wq_r   <= s2_wprod[WdayRecipShift +: 13];
    s2_days_r <= s1_days_r;
    s2_secs_r <= s1_secs_r;
  end

  // stage 3: time of day, day within estimated year, weekday
  assign s3_tod_nxt  = 17'(s2_secs_r - s2_dsec_r);
  assign s3_rem0_nxt = {1'b0, s2_days_r} - {1'b0, year_start(s2_yo_r)};
  assign s3_wday_nxt = 3'(s2_wd_r - 16'(16'(s2_wq_r) * 16'd7));

  always_ff @(posedge clk) begin
    s3_tod_r  <= s3_tod_nxt;
    s3_rem0_r <= s3_rem0_nxt;
    s3_wday_r <= s3_wday_nxt;
    s3_yo_r   <= s2_yo_r;
  end

  // stage 4: step back an overshooting year, hour
  assign s4_hprod    = 27'(s3_tod_r[16:4]) * 27'(HOUR_RECIP);
  assign s4_hour_nxt = s4_hprod[HourRecipShift +: 5];

  always_comb begin
    if (s3_rem0_r[16]) begin
      s4_yo_nxt  = s3_yo_r - 8'd1;
      s4_rem_nxt = 9'(s3_rem0_r + 17'(DAYS_PER_YEAR) + 17'(is_leap(s4_yo_nxt)));
    end else begin
      s4_yo_nxt  = s3_yo_r;
      s4_rem_nxt = 9'(s3_rem0_r);
    end
  end

  always_ff @(posedge clk) begin
    s4_hour_r <= s4_hour_nxt;
    s4_yo_r   <= s4_yo_nxt;
    s4_rem_r  <= s4_rem_nxt;
    s4_leap_r <= is_leap(s4_yo_nxt);
    s4_tod_r  <= s3_tod_r;
    s4_wday_r <= s3_wday_r;
  end

  // stage 5: month and day of month, seconds within hour
  assign s5_rest_nxt = 12'(s4_tod_r - 17'(17'(s4_hour_r) * 17'(SECS_PER_HOUR)));

  always_comb begin
    s5_date_nxt.month = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s4_rem_r >= month_start(4'(m), s4_leap_r)) begin
        s5_date_nxt.month = 4'(m);
      end
    end
    s5_date_nxt.dom  = 5'(s4_rem_r - month_start(s5_date_nxt.month, s4_leap_r) + 9'd1);
    s5_date_nxt.year = BASE_YEAR + 12'(s4_yo_r);
    s5_date_nxt.hour = s4_hour_r;
    s5_date_nxt.wday = s4_wday_r;
    s5_date_nxt.yday = s4_rem_r + 9'd1;
  end

  always_ff @(posedge clk) begin
    s5_rest_r <= s5_rest_nxt;
    s5_date_r <= s5_date_nxt;
  end

  // stage 6: minute
  assign s6_mprod   = 21'(s5_rest_r[11:2]) * 21'(MIN_RECIP);
  assign s6_min_nxt = s6_mprod[MinRecipShift +: 6];

  always_ff @(posedge clk) begin
    s6_min_r  <= s6_min_nxt;
    s6_rest_r <= s5_rest_r;
    s6_date_r <= s5_date_r;
  end

  // stage 7: second, output registers
  assign s7_sec_nxt = 6'(s6_rest_r - 12'(12'(s6_min_r) * 12'(SECS_PER_MIN)));

  always_ff @(posedge clk) begin
    out_year_full        <= s6_date_r.year;
    out_month_index      <= s6_date_r.month;
    out_day_of_month     <= s6_date_r.dom;
    out_hour_of_day      <= s6_date_r.hour;
    out_minute_of_hour   <= s6_min_r;
    out_second_of_minute <= s7_sec_nxt;
    out_weekday          <= s6_date_r.wday;
    out_day_of_year      <= s6_date_r.yday;
  end

  assign out_valid = v_r[6];

endmodule

`default_nettype wire
